FILE: rtl/pbat_pkg.sv
`timescale 1ns / 1ps
// Package for the power-of-two block allocator: record table sizing, codes,
// channel payload types and the size rounding function. No dependencies.
package pbat_pkg;

   localparam int REC_CNT   = 256;
   localparam int REC_IDX_W = $clog2(REC_CNT);
   localparam int REC_CNT_W = REC_IDX_W + 1;
   localparam int ITER_MAX  = REC_CNT + 2;
   localparam int ITER_W    = $clog2(ITER_MAX + 1);
   localparam int AW        = 36;
   localparam int CNT_SAT   = 511;

   localparam logic [1:0] OP_ALLOC     = 2'd0;
   localparam logic [1:0] OP_FREE_ADDR = 2'd1;
   localparam logic [1:0] OP_FREE_PROC = 2'd2;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_TOO_LARGE  = 3'd1;
   localparam logic [2:0] ST_NO_SPACE   = 3'd2;
   localparam logic [2:0] ST_TABLE_FULL = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND  = 3'd4;

   localparam logic [1:0] CSR_ALLOC_BASE  = 2'd0;
   localparam logic [1:0] CSR_REGION_END  = 2'd1;
   localparam logic [1:0] CSR_ALLOC_LIMIT = 2'd2;
   localparam logic [1:0] CSR_MIN_BLOCK   = 2'd3;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] req_size;
      logic [31:0] address;
      logic [31:0] virt_addr;
      logic [7:0]  owner_pid;
      logic [7:0]  owner_cpu;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] block_addr;
      logic [31:0] granted_size;
      logic [8:0]  freed_count;
   } rsp_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] size;
      logic [31:0] vaddr;
      logic [7:0]  pid;
      logic [7:0]  cpu;
   } rec_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   // Round up to a power of two; zero stays zero, result may reach 2^32.
   function automatic logic [32:0] round_pow2(input logic [31:0] s);
      logic [31:0] t;
      t = s - 32'd1;
      t = t | (t >> 1);
      t = t | (t >> 2);
      t = t | (t >> 4);
      t = t | (t >> 8);
      t = t | (t >> 16);
      if (s == 32'd0) begin
         return 33'd0;
      end
      return {1'b0, t} + 33'd1;
   endfunction

endpackage

FILE: rtl/pbat_rec_store.sv
`timescale 1ns / 1ps
// Allocation record store: one write port, one registered read port.
// Depends on pbat_pkg.
module pbat_rec_store
   import pbat_pkg::*;
(
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [REC_IDX_W-1:0] wr_idx,
   input  rec_type              wr_rec,
   input  logic                 rd_en,
   input  logic [REC_IDX_W-1:0] rd_idx,
   output rec_type              rd_rec
);

   rec_type mem [REC_CNT];
   rec_type rd_rec_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_idx] <= wr_rec;
      end
      if (rd_en) begin
         rd_rec_ff <= mem[rd_idx];
      end
   end

   assign rd_rec = rd_rec_ff;

endmodule

FILE: rtl/pbat_rem_div.sv
`timescale 1ns / 1ps
// Bit-serial restoring divider that returns the remainder only, one bit a cycle.
// Depends on pbat_pkg.
module pbat_rem_div
   import pbat_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [32:0]  dividend,
   input  logic [31:0]  divisor,
   output div_stat_type stat,
   output logic [31:0]  rem
);

   logic [5:0]  cnt_ff, cnt_in;
   logic [32:0] num_ff, num_in;
   logic [31:0] div_ff, div_in;
   logic [31:0] rem_ff, rem_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, num_ff[32]};
      if (start) begin
         cnt_in  = 6'd33;
         num_in  = dividend;
         div_in  = divisor;
         rem_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = {num_ff[31:0], 1'b0};
         if (trial >= {1'b0, div_ff}) begin
            rem_in = 32'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[31:0];
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign rem       = rem_ff;

endmodule

FILE: rtl/pow2_block_allocator_table_top.sv
`timescale 1ns / 1ps
// Power-of-two first-fit block allocator, one item at a time; req_stall stays high
// until the result is loaded. Frees: a scan of the record table, one record read a
// cycle, then the result is loaded. Allocate: a sizing step, then per candidate slot
// a fit check, a record scan and, on a hit, a remainder division, for up to REC_CNT+2
// slots; then a search of the table for a free record.
// Synchronous reset clears all record valid bits and loads register defaults.
module pow2_block_allocator_table_top
   import pbat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [32:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_IDLE, S_SIZE, S_FIT, S_SCAN, S_DIV, S_FREE, S_DONE
   } state_type;

   state_type            state_ff, state_in;
   req_type              req_ff, req_in;
   rsp_type              res_ff, res_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          size_ff, size_in;
   logic [AW-1:0]        addr_ff, addr_in;
   logic [ITER_W-1:0]    iter_ff, iter_in;
   logic [REC_CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [REC_IDX_W-1:0] chk_idx_ff, chk_idx_in;
   logic [32:0]          diff_ff, diff_in;
   logic [REC_CNT-1:0]   valid_ff, valid_in;
   logic [31:0]          base_ff, limit_ff, minb_ff;
   logic [32:0]          rend_ff;

   logic [32:0]          rounded;
   logic [AW-1:0]        end_w, ra, re, ceilm;
   logic                 no_fit, ovl_hit, rec_live;
   logic                 rd_en, wr_en, div_start;
   rec_type              rd_rec, wr_rec;
   div_stat_type         div_stat;
   logic [31:0]          div_rem;

   pbat_rec_store u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_idx (scan_idx_ff[REC_IDX_W-1:0]),
      .wr_rec (wr_rec),
      .rd_en  (rd_en),
      .rd_idx (scan_idx_ff[REC_IDX_W-1:0]),
      .rd_rec (rd_rec)
   );

   pbat_rem_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (diff_in),
      .divisor  (size_ff),
      .stat     (div_stat),
      .rem      (div_rem)
   );

   always_comb begin
      rounded  = round_pow2(req_ff.req_size);
      end_w    = addr_ff + AW'(size_ff);
      no_fit   = (end_w > AW'(rend_ff)) || (end_w > (AW'(1) << 32));
      ra       = AW'(rd_rec.addr);
      re       = ra + AW'(rd_rec.size);
      rec_live = valid_ff[chk_idx_ff];
      ovl_hit  = rec_live && (rd_rec.size != 32'd0) && (size_ff != 32'd0)
                 && (ra < end_w) && (addr_ff < re);
      ceilm    = AW'(diff_ff) + ((div_rem == 32'd0) ? AW'(0) : AW'(size_ff - div_rem));

      wr_rec.addr  = addr_ff[31:0];
      wr_rec.size  = size_ff;
      wr_rec.vaddr = (req_ff.virt_addr != 32'd0) ? req_ff.virt_addr : addr_ff[31:0];
      wr_rec.pid   = req_ff.owner_pid;
      wr_rec.cpu   = req_ff.owner_cpu;

      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      size_in      = size_ff;
      addr_in      = addr_ff;
      iter_in      = iter_ff;
      scan_idx_in  = scan_idx_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      diff_in      = diff_ff;
      valid_in     = valid_ff;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      div_start    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in      = req_data;
               res_in      = '0;
               scan_idx_in = '0;
               unique case (req_data.operation)
                  OP_ALLOC:     state_in = S_SIZE;
                  OP_FREE_ADDR: state_in = S_SCAN;
                  OP_FREE_PROC: state_in = S_SCAN;
                  default:      state_in = S_DONE;
               endcase
            end
         end
         S_SIZE: begin
            if (rounded[32] || (rounded[31:0] > limit_ff)) begin
               res_in.status = ST_TOO_LARGE;
               state_in      = S_DONE;
            end else begin
               size_in = (rounded[31:0] < minb_ff) ? minb_ff : rounded[31:0];
               res_in.granted_size = size_in;
               addr_in  = AW'(base_ff) + AW'(size_in);
               iter_in  = '0;
               state_in = S_FIT;
            end
         end
         S_FIT: begin
            if ((iter_ff == ITER_W'(ITER_MAX)) || no_fit) begin
               res_in.status = ST_NO_SPACE;
               state_in      = S_DONE;
            end else begin
               scan_idx_in = '0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            // issue the next read while the previous record is checked
            if (!scan_idx_ff[REC_IDX_W]) begin
               rd_en       = 1'b1;
               chk_idx_in  = scan_idx_ff[REC_IDX_W-1:0];
               chk_vld_in  = 1'b1;
               scan_idx_in = scan_idx_ff + REC_CNT_W'(1);
            end
            if (chk_vld_ff) begin
               priority case (req_ff.operation)
                  OP_ALLOC: begin
                     if (ovl_hit) begin
                        // hold the blocking record's end offset for the slot jump
                        diff_in    = 33'(re - AW'(base_ff));
                        div_start  = 1'b1;
                        chk_vld_in = 1'b0;
                        state_in   = S_DIV;
                     end
                  end
                  OP_FREE_ADDR: begin
                     if (rec_live && (rd_rec.addr == req_ff.address)) begin
                        valid_in[chk_idx_ff] = 1'b0;
                        res_in.status        = ST_OK;
                        res_in.freed_count   = 9'd1;
                        chk_vld_in           = 1'b0;
                        state_in             = S_DONE;
                     end
                  end
                  default: begin
                     if (rec_live && (rd_rec.pid == req_ff.owner_pid)
                         && (rd_rec.cpu == req_ff.owner_cpu)) begin
                        valid_in[chk_idx_ff] = 1'b0;
                        if (res_ff.freed_count != 9'(CNT_SAT)) begin
                           res_in.freed_count = res_ff.freed_count + 9'd1;
                        end
                     end
                  end
               endcase
            end else if (scan_idx_ff[REC_IDX_W]) begin
               priority case (req_ff.operation)
                  OP_ALLOC: begin
                     scan_idx_in = '0;
                     state_in    = S_FREE;
                  end
                  OP_FREE_ADDR: begin
                     res_in.status = ST_NOT_FOUND;
                     state_in      = S_DONE;
                  end
                  default: begin
                     res_in.status = ST_OK;
                     state_in      = S_DONE;
                  end
               endcase
            end
         end
         S_DIV: begin
            // advance to the first slot at or past the blocking record's end
            if (div_stat.done) begin
               addr_in  = AW'(base_ff) + ceilm;
               iter_in  = iter_ff + ITER_W'(1);
               state_in = S_FIT;
            end
         end
         S_FREE: begin
            if (scan_idx_ff[REC_IDX_W]) begin
               res_in.status = ST_TABLE_FULL;
               state_in      = S_DONE;
            end else if (!valid_ff[scan_idx_ff[REC_IDX_W-1:0]]) begin
               wr_en         = 1'b1;
               valid_in[scan_idx_ff[REC_IDX_W-1:0]] = 1'b1;
               res_in.status     = ST_OK;
               res_in.block_addr = addr_ff[31:0];
               state_in          = S_DONE;
            end else begin
               scan_idx_in = scan_idx_ff + REC_CNT_W'(1);
            end
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
         valid_ff     <= '0;
         iter_ff      <= '0;
         base_ff      <= 32'h0100_0000;
         rend_ff      <= '0;
         limit_ff     <= '0;
         minb_ff      <= 32'd4096;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         valid_ff     <= valid_in;
         iter_ff      <= iter_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_ALLOC_BASE:  base_ff  <= csr_wdata[31:0];
               CSR_REGION_END:  rend_ff  <= csr_wdata;
               CSR_ALLOC_LIMIT: limit_ff <= csr_wdata[31:0];
               CSR_MIN_BLOCK:   minb_ff  <= csr_wdata[31:0];
               default: ;
            endcase
         end
      end
      req_ff      <= req_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      size_ff     <= size_in;
      addr_ff     <= addr_in;
      scan_idx_ff <= scan_idx_in;
      chk_idx_ff  <= chk_idx_in;
      diff_ff     <= diff_in;
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_fail_no_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.status != ST_OK) |-> rsp_data_ff.block_addr == 32'd0)
      else $error("failed request carries an address");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_stat.busy)
      else $error("divider started while busy");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      iter_ff <= ITER_W'(ITER_MAX))
      else $error("slot iteration count out of range");

   a_free_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.freed_count != 9'd0)
      |-> rsp_data_ff.granted_size == 32'd0)
      else $error("free result carries a granted size");

endmodule

FILE: test/pow2_block_allocator_table_checker.sv
`timescale 1ns / 1ps
// Checker for the block allocator: mirrors the register writes, predicts each
// response from its own copy of the record table and compares. Uses pbat_pkg.
module pow2_block_allocator_table_checker
   import pbat_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  req_type     req_data,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  rsp_type     rsp_data,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [32:0] csr_wdata,
   output int          mismatches,
   output int          outstanding,
   output logic        transfer_seen
);

   localparam int TABLE_SIZE = 256;

   logic [63:0] base_q, end_q, limit_q, minb_q;
   logic        live [TABLE_SIZE];
   logic [31:0] blk_addr [TABLE_SIZE];
   logic [31:0] blk_size [TABLE_SIZE];
   logic [7:0]  blk_pid [TABLE_SIZE];
   logic [7:0]  blk_cpu [TABLE_SIZE];
   rsp_type     expected_rsps [$];

   function automatic logic [63:0] ceil_pow2(input logic [31:0] s);
      int p;
      logic [63:0] r;
      if (s == 32'd0) return 64'd0;
      p = 31;
      while (p > 0 && !s[p]) p--;
      r = 64'd1 << p;
      if (r != {32'd0, s}) r = r << 1;
      return r;
   endfunction

   function automatic int first_overlap(input logic [63:0] a, input logic [63:0] sz);
      logic [63:0] ra, re;
      if (sz == 64'd0) return -1;
      for (int i = 0; i < TABLE_SIZE; i++) begin
         if (live[i] && blk_size[i] != 32'd0) begin
            ra = {32'd0, blk_addr[i]};
            re = ra + blk_size[i];
            if (ra < a + sz && a < re) return i;
         end
      end
      return -1;
   endfunction

   task automatic allocate(input req_type r, output rsp_type o);
      logic [63:0] size, a, e, diff;
      int hit, iter, slot;
      o = '0;
      size = ceil_pow2(r.req_size);
      if (size > 64'hFFFF_FFFF || size > limit_q) begin
         o.status = ST_TOO_LARGE;
         return;
      end
      if (size < minb_q) size = minb_q;
      o.granted_size = size[31:0];
      a = base_q + size;
      for (iter = 0; iter <= TABLE_SIZE + 1; iter++) begin
         e = a + size;
         if (e > end_q || e > 64'h1_0000_0000) begin
            o.status = ST_NO_SPACE;
            return;
         end
         hit = first_overlap(a, size);
         if (hit < 0) break;
         // jump to the first slot at or past the end of the blocking record
         diff = {32'd0, blk_addr[hit]} + blk_size[hit] - base_q;
         a = base_q + ((diff + size - 1) / size) * size;
      end
      if (iter > TABLE_SIZE + 1) begin
         o.status = ST_NO_SPACE;
         return;
      end
      slot = -1;
      for (int i = 0; i < TABLE_SIZE; i++)
         if (!live[i] && slot < 0) slot = i;
      if (slot < 0) begin
         o.status = ST_TABLE_FULL;
         return;
      end
      live[slot] = 1'b1;
      blk_addr[slot] = a[31:0];
      blk_size[slot] = size[31:0];
      blk_pid[slot] = r.owner_pid;
      blk_cpu[slot] = r.owner_cpu;
      o.status = ST_OK;
      o.block_addr = a[31:0];
   endtask

   task automatic predict_rsp(input req_type r, output rsp_type o);
      int cnt;
      o = '0;
      cnt = 0;
      case (r.operation)
         OP_ALLOC: allocate(r, o);
         OP_FREE_ADDR: begin
            o.status = ST_NOT_FOUND;
            for (int i = 0; i < TABLE_SIZE; i++) begin
               if (o.status == ST_NOT_FOUND && live[i] && blk_addr[i] == r.address) begin
                  live[i] = 1'b0;
                  o.status = ST_OK;
                  o.freed_count = 9'd1;
               end
            end
         end
         OP_FREE_PROC: begin
            for (int i = 0; i < TABLE_SIZE; i++) begin
               if (live[i] && blk_pid[i] == r.owner_pid && blk_cpu[i] == r.owner_cpu) begin
                  live[i] = 1'b0;
                  if (cnt < CNT_SAT) cnt++;
               end
            end
            o.status = ST_OK;
            o.freed_count = cnt[8:0];
         end
         default: o = '0;
      endcase
   endtask

   task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
      $display("%0t: %s got %0h want %0h", $realtime, field, got, want);
      mismatches++;
   endtask

   assign outstanding = expected_rsps.size();

   // Sample on the falling edge: everything seen here transfers on the next rising edge.
   always @(negedge clock) begin
      rsp_type want, got;
      if (reset) begin
         base_q <= 64'd16777216;
         end_q <= 64'd0;
         limit_q <= 64'd0;
         minb_q <= 64'd4096;
         for (int i = 0; i < TABLE_SIZE; i++) live[i] = 1'b0;
         expected_rsps.delete();
         mismatches = 0;
         transfer_seen <= 1'b0;
      end else begin
         transfer_seen <= (req_valid && !req_stall) || (rsp_valid && !rsp_stall);
         if (csr_we) begin
            case (csr_index)
               CSR_ALLOC_BASE:  base_q = {32'd0, csr_wdata[31:0]};
               CSR_REGION_END:  end_q = {31'd0, csr_wdata};
               CSR_ALLOC_LIMIT: limit_q = {32'd0, csr_wdata[31:0]};
               CSR_MIN_BLOCK:   minb_q = {32'd0, csr_wdata[31:0]};
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            got = rsp_data;
            if (expected_rsps.size() == 0) begin
               report("unexpected transfer", 32'd0, 32'd0);
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status) report("status", got.status, want.status);
               if (got.block_addr !== want.block_addr)
                  report("block_addr", got.block_addr, want.block_addr);
               if (got.granted_size !== want.granted_size)
                  report("granted_size", got.granted_size, want.granted_size);
               if (got.freed_count !== want.freed_count)
                  report("freed_count", got.freed_count, want.freed_count);
            end
         end
         if (req_valid && !req_stall) begin
            predict_rsp(req_data, want);
            expected_rsps.push_back(want);
         end
      end
   end

endmodule

FILE: test/pow2_block_allocator_table_top_tb.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the block allocator: directed and random requests
// under several register settings. Needs pbat_pkg and the allocator checker.
module pow2_block_allocator_table_top_tb;
   import pbat_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int QUIET_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_ALLOC_BASE;
   logic [32:0] csr_wdata = '0;
   int          mismatches, outstanding, quiet;
   logic        transfer_seen;
   logic        gaps_on = 1'b1;
   logic        hold_rsp = 1'b0;
   logic [31:0] cur_base, cur_min;

   always #5 clock = ~clock;

   pow2_block_allocator_table_top dut (.*);

   pow2_block_allocator_table_checker chk (.*);

   always @(posedge clock) begin
      if (reset || transfer_seen) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Response side: random stall before each transfer while gaps are on, plus one long hold.
   initial begin
      int d;
      logic ok;
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            repeat (3000) @(posedge clock);
            hold_rsp <= 1'b0;
         end
         d = gaps_on ? $urandom_range(0, 9) : 0;
         if (d > 0) begin
            rsp_stall <= 1'b1;
            repeat (d) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do begin
            @(negedge clock);
            ok = rsp_valid;
            @(posedge clock);
         end while (!ok);
      end
   end

   task automatic send(input req_type r);
      int d;
      logic ok;
      d = gaps_on ? $urandom_range(0, 9) : 0;
      if (d > 0) begin
         req_valid <= 1'b0;
         repeat (d) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do begin
         @(negedge clock);
         ok = !req_stall;
         @(posedge clock);
      end while (!ok);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] base, input logic [32:0] rend,
                            input logic [31:0] lim, input logic [31:0] minb);
      csr_we <= 1'b1;
      csr_index <= CSR_ALLOC_BASE;
      csr_wdata <= {1'b0, base};
      @(posedge clock);
      csr_index <= CSR_REGION_END;
      csr_wdata <= rend;
      @(posedge clock);
      csr_index <= CSR_ALLOC_LIMIT;
      csr_wdata <= {1'b0, lim};
      @(posedge clock);
      csr_index <= CSR_MIN_BLOCK;
      csr_wdata <= {1'b0, minb};
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      cur_base = base;
      cur_min = minb;
   endtask

   function automatic req_type mk(input logic [1:0] op, input logic [31:0] size,
                                  input logic [31:0] a, input logic [31:0] v,
                                  input logic [7:0] pid, input logic [7:0] cpu);
      req_type r;
      r.operation = op;
      r.req_size = size;
      r.address = a;
      r.virt_addr = v;
      r.owner_pid = pid;
      r.owner_cpu = cpu;
      return r;
   endfunction

   function automatic req_type random_req();
      req_type r;
      int k;
      logic [63:0] span;
      k = $urandom_range(0, 99);
      r.operation = OP_ALLOC;
      span = {32'd0, cur_min} * 4;
      if (span > 64'hFFFF_FFFF) span = 64'hFFFF_FFFF;
      r.req_size = (k < 5) ? $urandom : $urandom_range(0, span[31:0]);
      r.address = ($urandom_range(0, 3) == 0) ? $urandom
                  : cur_base + cur_min * $urandom_range(1, 24);
      r.virt_addr = $urandom_range(0, 1) ? 32'd0 : $urandom;
      r.owner_pid = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      r.owner_cpu = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
      if (k >= 95) r.operation = OP_UNUSED;
      else if (k >= 75) r.operation = OP_FREE_PROC;
      else if (k >= 55) r.operation = OP_FREE_ADDR;
      return r;
   endfunction

   initial begin
      logic [31:0] b, m;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      cur_base = 32'h0100_0000;
      cur_min = 32'd4096;

      // Reset values: empty region, zero limit.
      send(mk(OP_ALLOC, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0));
      send(mk(OP_ALLOC, 32'd1, 32'd0, 32'd0, 8'd0, 8'd0));
      send(mk(OP_FREE_ADDR, 32'd0, 32'h0100_1000, 32'd0, 8'd0, 8'd0));
      send(mk(OP_FREE_PROC, 32'd0, 32'd0, 32'd0, 8'd0, 8'd0));
      send(mk(OP_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
      drain();

      configure(32'h1000_0000, 33'h1010_0000, 32'h0001_0000, 32'd4096);
      send(mk(OP_ALLOC, 32'd1, 32'd0, 32'd0, 8'd1, 8'd1));
      send(mk(OP_ALLOC, 32'd5000, 32'd0, 32'hABCD_0000, 8'd1, 8'd2));
      send(mk(OP_ALLOC, 32'h0001_0000, 32'd0, 32'd0, 8'd2, 8'd1));
      send(mk(OP_ALLOC, 32'h0001_0001, 32'd0, 32'd0, 8'd2, 8'd1));
      send(mk(OP_ALLOC, 32'hFFFF_FFFF, 32'd0, 32'd0, 8'd2, 8'd1));
      send(mk(OP_ALLOC, 32'h8000_0001, 32'd0, 32'd0, 8'd2, 8'd1));
      send(mk(OP_FREE_ADDR, 32'd0, 32'h1000_1000, 32'd0, 8'd0, 8'd0));
      send(mk(OP_FREE_ADDR, 32'd0, 32'h1000_1000, 32'd0, 8'd0, 8'd0));
      send(mk(OP_FREE_PROC, 32'd0, 32'd0, 32'd0, 8'd1, 8'd2));
      send(mk(OP_FREE_PROC, 32'd0, 32'd0, 32'd0, 8'd2, 8'd1));
      drain();

      // Top of the address space: the slot may end exactly at 2^32.
      configure(32'hFFFF_0000, 33'h1_FFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
      send(mk(OP_ALLOC, 32'h0000_8000, 32'd0, 32'd0, 8'd3, 8'd3));
      send(mk(OP_ALLOC, 32'h0000_8000, 32'd0, 32'd0, 8'd3, 8'd3));
      send(mk(OP_FREE_PROC, 32'd0, 32'd0, 32'd0, 8'd3, 8'd3));
      drain();
      configure(32'd0, 33'h1_0000_0000, 32'h8000_0000, 32'h8000_0000);
      send(mk(OP_ALLOC, 32'd0, 32'd0, 32'd0, 8'd4, 8'd4));
      send(mk(OP_ALLOC, 32'd7, 32'd0, 32'd0, 8'd4, 8'd4));
      send(mk(OP_FREE_PROC, 32'd0, 32'd0, 32'd0, 8'd4, 8'd4));
      drain();
      // Odd minimum block, not a power of two.
      configure(32'h0000_1000, 33'h0000_2000, 32'h0000_0100, 32'd3);
      send(mk(OP_ALLOC, 32'd1, 32'd0, 32'd0, 8'd4, 8'd4));
      send(mk(OP_ALLOC, 32'd2, 32'd0, 32'd0, 8'd4, 8'd4));
      send(mk(OP_FREE_PROC, 32'd0, 32'd0, 32'd0, 8'd4, 8'd4));
      drain();

      // Zero-size blocks overlap nothing: fill the table cheaply.
      configure(32'h0000_0100, 33'h0000_1000, 32'd0, 32'd0);
      for (int i = 0; i < 257; i++)
         send(mk(OP_ALLOC, 32'd0, 32'd0, 32'd0, 8'd5, 8'd6));
      send(mk(OP_ALLOC, 32'd1, 32'd0, 32'd0, 8'd5, 8'd6));
      send(mk(OP_FREE_PROC, 32'd0, 32'd0, 32'd0, 8'd5, 8'd6));
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         gaps_on = (ph % 3) != 0;
         if (ph == 7) begin
            configure(32'd0, 33'h1_FFFF_FFFF, 32'hFFFF_FFFF, 32'd4096);
         end else begin
            m = 32'd1 << $urandom_range(0, 16);
            b = $urandom_range(0, 32'hF000_0000) & ~(m - 1);
            configure(b, {1'b0, b} + {1'b0, m} * $urandom_range(4, 20),
                      m << $urandom_range(0, 3), m);
         end
         if (ph == 2) hold_rsp <= 1'b1;
         for (int i = 0; i < 111; i++) begin
            if (ph == 4 && i == 70) drain();
            send(random_req());
         end
         drain();
      end

      repeat (50) @(posedge clock);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

FILE: pow2_block_allocator_table_top.f
rtl/pbat_pkg.sv
rtl/pbat_rec_store.sv
rtl/pbat_rem_div.sv
rtl/pow2_block_allocator_table_top.sv
test/pow2_block_allocator_table_checker.sv
test/pow2_block_allocator_table_top_tb.sv
